// ===== hdl/bcdalu_pkg.sv =====
// Shared types, operation codes and flag positions for the byte ALU.
package bcdalu_pkg;

  localparam int ModeW = 4;
  localparam int ByteW = 8;

  // operation codes
  localparam logic [ModeW-1:0] MODE_INC = 4'd0;
  localparam logic [ModeW-1:0] MODE_DEC = 4'd1;
  localparam logic [ModeW-1:0] MODE_OR  = 4'd2;
  localparam logic [ModeW-1:0] MODE_AND = 4'd3;
  localparam logic [ModeW-1:0] MODE_XOR = 4'd4;
  localparam logic [ModeW-1:0] MODE_ADC = 4'd5;
  localparam logic [ModeW-1:0] MODE_SBC = 4'd6;
  localparam logic [ModeW-1:0] MODE_CMP = 4'd7;
  localparam logic [ModeW-1:0] MODE_ASL = 4'd8;
  localparam logic [ModeW-1:0] MODE_LSR = 4'd9;
  localparam logic [ModeW-1:0] MODE_ROL = 4'd10;
  localparam logic [ModeW-1:0] MODE_ROR = 4'd11;
  localparam logic [ModeW-1:0] MODE_BIT = 4'd12;

  // status bit positions
  localparam int FLAG_N = 7;
  localparam int FLAG_V = 6;
  localparam int FLAG_D = 3;
  localparam int FLAG_Z = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [ByteW-1:0] status_in;
    logic [ByteW-1:0] operand;
    logic [ByteW-1:0] acc;
    logic [ModeW-1:0] mode;
  } alu_req_t;

  typedef struct packed {
    logic             writes_back;
    logic [ByteW-1:0] status_out;
    logic [ByteW-1:0] result;
  } alu_res_t;

  localparam int ReqW = $bits(alu_req_t);
  localparam int ResW = $bits(alu_res_t);

endpackage

// ===== hdl/bcdalu_stage.sv =====
// One registered pipeline stage with valid/ready flow control.
module bcdalu_stage
  import bcdalu_pkg::*;
#(
  parameter int W = ReqW
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r, valid_nxt;
  logic [W-1:0] data_r;

  // stage refills in the same cycle its word leaves
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== hdl/bcdalu_alu.sv =====
// Combinational byte ALU: logic ops, shifts, binary and BCD add/subtract.
module bcdalu_alu
  import bcdalu_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  function automatic logic [1:0] nz_of(input logic [ByteW-1:0] v);
    nz_of = {v[ByteW-1], v == '0};  // {N, Z}
  endfunction

  logic [ByteW-1:0] a, b, st;
  logic             c;

  // binary add / subtract
  logic [ByteW:0]   add_bin, sub_bin;
  logic             add_v, sub_v;

  // decimal add
  logic [4:0]       dlo_sum, dlo_adj;
  logic [ByteW:0]   dsum;
  logic [ByteW+1:0] dsum_adj;
  logic             dadd_v;

  // decimal subtract, two's complement in 6 and 10 bits
  logic [5:0]       slo, slo_m6, slo_adj;
  logic [9:0]       sdiff, sdiff_adj;

  logic [ByteW-1:0] cmp_diff;
  logic [ByteW-1:0] r;
  logic [ByteW-1:0] f;
  logic             wb;

  assign a  = req.acc;
  assign b  = req.operand;
  assign st = req.status_in;
  assign c  = st[FLAG_C];

  assign add_bin = {1'b0, a} + {1'b0, b} + {{ByteW{1'b0}}, c};
  assign sub_bin = {1'b0, a} + {1'b0, ~b} + {{ByteW{1'b0}}, c};
  assign add_v   = (a[7] ^ add_bin[7]) & (b[7] ^ add_bin[7]);
  assign sub_v   = (a[7] ^ b[7]) & (a[7] ^ sub_bin[7]);

  always_comb begin
    dlo_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c};
    if (dlo_sum >= 5'd10) begin
      dlo_adj = {1'b1, dlo_sum[3:0] + 4'd6};
    end else begin
      dlo_adj = dlo_sum;
    end
    dsum     = {1'b0, a[7:4], 4'b0} + {1'b0, b[7:4], 4'b0} + {4'b0, dlo_adj};
    dadd_v   = (a[7] ^ dsum[7]) & (b[7] ^ dsum[7]);
    if (dsum >= 9'h0a0) begin
      dsum_adj = {1'b0, dsum} + 10'h060;
    end else begin
      dsum_adj = {1'b0, dsum};
    end
  end

  always_comb begin
    slo    = {2'b0, a[3:0]} - {2'b0, b[3:0]} + {5'b0, c} - 6'd1;
    slo_m6 = slo - 6'd6;
    // a negative low digit becomes -16 plus the adjusted nibble
    if (slo[5]) begin
      slo_adj = {2'b11, slo_m6[3:0]};
    end else begin
      slo_adj = slo;
    end
    sdiff = {2'b0, a[7:4], 4'b0} - {2'b0, b[7:4], 4'b0} + {{4{slo_adj[5]}}, slo_adj};
    if (sdiff[9]) begin
      sdiff_adj = sdiff - 10'h060;
    end else begin
      sdiff_adj = sdiff;
    end
  end

  assign cmp_diff = a - b;

  always_comb begin
    r  = '0;
    f  = st;
    wb = 1'b1;
    unique case (req.mode)
      MODE_INC: begin
        r = b + 8'd1;
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
      end
      MODE_DEC: begin
        r = b - 8'd1;
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
      end
      MODE_OR: begin
        r = a | b;
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
      end
      MODE_AND: begin
        r = a & b;
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
      end
      MODE_XOR: begin
        r = a ^ b;
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
      end
      MODE_ADC: begin
        if (!st[FLAG_D]) begin
          r = add_bin[7:0];
          {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
          f[FLAG_C] = add_bin[8];
          f[FLAG_V] = add_v;
        end else begin
          // N and V from the sum before high-digit adjust, Z from binary sum
          r = dsum_adj[7:0];
          f[FLAG_N] = dsum[7];
          f[FLAG_V] = dadd_v;
          f[FLAG_Z] = add_bin[7:0] == '0;
          f[FLAG_C] = dsum_adj[9:8] != 2'b0;
        end
      end
      MODE_SBC: begin
        {f[FLAG_N], f[FLAG_Z]} = nz_of(sub_bin[7:0]);
        f[FLAG_C] = sub_bin[8];
        f[FLAG_V] = sub_v;
        r = st[FLAG_D] ? sdiff_adj[7:0] : sub_bin[7:0];
      end
      MODE_CMP: begin
        {f[FLAG_N], f[FLAG_Z]} = nz_of(cmp_diff);
        f[FLAG_C] = a >= b;
        wb = 1'b0;
      end
      MODE_ASL: begin
        r = {b[6:0], 1'b0};
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
        f[FLAG_C] = b[7];
      end
      MODE_LSR: begin
        r = {1'b0, b[7:1]};
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
        f[FLAG_C] = b[0];
      end
      MODE_ROL: begin
        r = {b[6:0], c};
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
        f[FLAG_C] = b[7];
      end
      MODE_ROR: begin
        r = {c, b[7:1]};
        {f[FLAG_N], f[FLAG_Z]} = nz_of(r);
        f[FLAG_C] = b[0];
      end
      MODE_BIT: begin
        f[FLAG_N] = b[7];
        f[FLAG_V] = b[6];
        f[FLAG_Z] = (a & b) == '0;
        wb = 1'b0;
      end
      default: begin
        wb = 1'b0;
      end
    endcase
  end

  assign res.result      = r;
  assign res.status_out  = f;
  assign res.writes_back = wb;

endmodule

// ===== hdl/byte_alu_with_bcd_flags_core.sv =====
// Top level of the byte ALU: input register, ALU logic, result register.
//
// Input stream in_*: one word per operation, carrying the operation code, the
// accumulator (or first compare operand), the second operand and the status
// byte. Result stream out_*: the result byte and updated status in tdata, the
// write-back flag in tuser (low for compare, bit test and unused codes; the
// result byte is then zero).
//
// An accepted word is captured in the input register, passes through the ALU
// logic and lands in the result register. Throughput is one word per cycle
// while out_tready stays high; the adder with its decimal adjust sits between
// the two registers.
//
// Each register refills in the cycle its word moves on, so a stall on
// out_tready holds the result and, once the input register is also full,
// drops in_tready; nothing is lost or repeated. Synchronous active-low reset
// empties both registers; no state survives between words.
module byte_alu_with_bcd_flags_core
  import bcdalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[3:0], acc[11:4], operand[19:12], status_in[27:20], zero pad
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result[7:0], status_out[15:8]
  output logic [15:0] out_tdata,
  // writes_back[0]
  output logic        out_tuser
);

  alu_req_t in_word, s1_word;
  alu_res_t alu_word, s2_word;
  logic     s1_valid, s1_ready;

  assign in_word = in_tdata[ReqW-1:0];

  bcdalu_stage #(.W(ReqW)) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_word),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_word)
  );

  bcdalu_alu u_alu (
    .req (s1_word),
    .res (alu_word)
  );

  bcdalu_stage #(.W(ResW)) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (alu_word),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (s2_word)
  );

  assign out_tdata = {s2_word.status_out, s2_word.result};
  assign out_tuser = s2_word.writes_back;

  // a word in the input register moves on whenever the result register is empty
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !out_tvalid) |=> out_tvalid)
    else $error("input word did not advance into empty result register");

  // an empty input register always takes a word
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_tready)
    else $error("input refused while input register empty");

  // D and the unused status bits are never touched
  a_status_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid |-> (alu_word.status_out[5:2] == s1_word.status_in[5:2]))
    else $error("status bits outside N V Z C changed");

  // no write-back means a zero result byte
  a_no_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[7:0] == 8'h00))
    else $error("non-zero result without write-back");

endmodule

// ===== verif/byte_alu_with_bcd_flags_core_tb.sv =====
// Self-checking testbench for the byte ALU: predicted results against the stream output.
module byte_alu_with_bcd_flags_core_tb;
  import bcdalu_pkg::*;

  localparam logic [7:0] ST_N = 8'(1 << FLAG_N);
  localparam logic [7:0] ST_V = 8'(1 << FLAG_V);
  localparam logic [7:0] ST_D = 8'(1 << FLAG_D);
  localparam logic [7:0] ST_C = 8'(1 << FLAG_C);
  localparam logic [3:0] MODE_SPARE = MODE_BIT + 4'd1;  // first unused code

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  alu_res_t alu_results_due[$];
  alu_res_t due_word;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       stall_cycles_left = 0;
  int       ops_sent = 0;
  int       results_seen = 0;
  int       error_count = 0;

  byte_alu_with_bcd_flags_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] with_nz(logic [7:0] st, logic [7:0] v);
    logic [7:0] f;
    f = st;
    f[FLAG_N] = v[7];
    f[FLAG_Z] = (v == 8'h00);
    return f;
  endfunction

  function automatic alu_res_t predict_alu(alu_req_t r);
    alu_res_t   o;
    logic [7:0] a, b, st, res, f;
    int         ia, ib, ci, bin, lo, sum, d;
    a = r.acc;
    b = r.operand;
    st = r.status_in;
    ia = a;
    ib = b;
    ci = st[FLAG_C];
    res = 8'h00;
    f = st;
    o.writes_back = 1'b1;
    case (r.mode)
      MODE_INC: begin res = b + 8'd1; f = with_nz(st, res); end
      MODE_DEC: begin res = b - 8'd1; f = with_nz(st, res); end
      MODE_OR:  begin res = a | b;    f = with_nz(st, res); end
      MODE_AND: begin res = a & b;    f = with_nz(st, res); end
      MODE_XOR: begin res = a ^ b;    f = with_nz(st, res); end
      MODE_ADC: begin
        bin = ia + ib + ci;
        if (!st[FLAG_D]) begin
          res = 8'(bin);
          f = with_nz(st, res);
          f[FLAG_V] = ((ia ^ bin) & (ib ^ bin) & 'h80) != 0;
          f[FLAG_C] = bin > 'hFF;
        end else begin
          lo = (ia & 'hF) + (ib & 'hF) + ci;
          if (lo >= 'hA) lo = ((lo + 6) & 'hF) + 'h10;
          sum = (ia & 'hF0) + (ib & 'hF0) + lo;
          // N and V are taken before the high digit is adjusted, Z from the binary sum
          f[FLAG_N] = sum[7];
          f[FLAG_V] = ((ia ^ sum) & (ib ^ sum) & 'h80) != 0;
          f[FLAG_Z] = (bin & 'hFF) == 0;
          if (sum >= 'hA0) sum += 'h60;
          f[FLAG_C] = sum > 'hFF;
          res = 8'(sum);
        end
      end
      MODE_SBC: begin
        bin = ia + (~ib & 'hFF) + ci;
        f = with_nz(st, 8'(bin));
        f[FLAG_V] = ((ia ^ ib) & (ia ^ bin) & 'h80) != 0;
        f[FLAG_C] = bin > 'hFF;
        if (!st[FLAG_D]) begin
          res = 8'(bin);
        end else begin
          lo = (ia & 'hF) - (ib & 'hF) + ci - 1;
          if (lo < 0) lo = ((lo - 6 + 32) & 'hF) - 'h10;
          d = (ia & 'hF0) - (ib & 'hF0) + lo;
          if (d < 0) d -= 'h60;
          res = 8'(d + 'h200);
        end
      end
      MODE_CMP: begin
        f = with_nz(st, 8'(ia - ib));
        f[FLAG_C] = ia >= ib;
        o.writes_back = 1'b0;
      end
      MODE_ASL: begin res = {b[6:0], 1'b0};         f = with_nz(st, res); f[FLAG_C] = b[7]; end
      MODE_LSR: begin res = {1'b0, b[7:1]};         f = with_nz(st, res); f[FLAG_C] = b[0]; end
      MODE_ROL: begin res = {b[6:0], st[FLAG_C]};   f = with_nz(st, res); f[FLAG_C] = b[7]; end
      MODE_ROR: begin res = {st[FLAG_C], b[7:1]};   f = with_nz(st, res); f[FLAG_C] = b[0]; end
      MODE_BIT: begin
        f[FLAG_N] = b[7];
        f[FLAG_V] = b[6];
        f[FLAG_Z] = (a & b) == 8'h00;
        o.writes_back = 1'b0;
      end
      default: o.writes_back = 1'b0;
    endcase
    o.result = res;
    o.status_out = f;
    return o;
  endfunction

  // Offers one word from the falling edge on; returns at the edge that takes it.
  task automatic send_op(logic [3:0] mode, logic [7:0] acc, logic [7:0] operand,
                         logic [7:0] status);
    alu_req_t req;
    req.mode = mode;
    req.acc = acc;
    req.operand = operand;
    req.status_in = status;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    alu_results_due.push_back(predict_alu(req));
    ops_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0: return {4'($urandom_range(9)), 4'($urandom_range(9))};  // valid BCD
      1: case ($urandom_range(7))
           0: return 8'h00;
           1: return 8'hFF;
           2: return 8'h80;
           3: return 8'h7F;
           4: return 8'h99;
           5: return 8'h09;
           6: return 8'h0F;
           default: return 8'h01;
         endcase
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_op();
    logic [3:0] mode;
    if ($urandom_range(99) < 5) mode = 4'($urandom_range(15, MODE_SPARE));
    else if ($urandom_range(99) < 30) mode = $urandom_range(1) ? MODE_ADC : MODE_SBC;
    else mode = 4'($urandom_range(MODE_BIT));
    send_op(mode, pick_byte(), pick_byte(), 8'($urandom));
  endtask

  // Result side: ready changes on the falling edge, a long hold-off wins over random stalls.
  always @(negedge clk) begin
    if (stall_cycles_left > 0) begin
      stall_cycles_left = stall_cycles_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (alu_results_due.size() == 0) begin
        $error("result word with none due: tdata %04h tuser %0b", out_tdata, out_tuser);
        error_count++;
      end else begin
        due_word = alu_results_due.pop_front();
        if (out_tdata[7:0] !== due_word.result) begin
          $error("result: expected %02h, got %02h", due_word.result, out_tdata[7:0]);
          error_count++;
        end
        if (out_tdata[15:8] !== due_word.status_out) begin
          $error("status_out: expected %02h, got %02h", due_word.status_out, out_tdata[15:8]);
          error_count++;
        end
        if (out_tuser !== due_word.writes_back) begin
          $error("writes_back: expected %0b, got %0b", due_word.writes_back, out_tuser);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_op(MODE_INC, 8'h00, 8'hFF, 8'h00);
    send_op(MODE_DEC, 8'hFF, 8'h00, 8'hFF);
    send_op(MODE_OR,  8'h00, 8'h00, ST_N);
    send_op(MODE_AND, 8'hFF, 8'h80, 8'h00);
    send_op(MODE_XOR, 8'hFF, 8'hFF, 8'h00);
    send_op(MODE_ADC, 8'h7F, 8'h01, 8'h00);                 // signed overflow
    send_op(MODE_ADC, 8'hFF, 8'h01, 8'h00);                 // carry out, zero
    send_op(MODE_ADC, 8'h99, 8'h01, ST_D);                  // decimal wrap: Z from binary sum
    send_op(MODE_ADC, 8'h09, 8'h01, ST_D);                  // low digit carries up
    send_op(MODE_ADC, 8'hFF, 8'hFF, ST_D | ST_C);           // non-BCD digits
    send_op(MODE_ADC, 8'h50, 8'h50, ST_D);                  // high digit adjust, V
    send_op(MODE_SBC, 8'h80, 8'h01, ST_C);
    send_op(MODE_SBC, 8'h10, 8'h01, ST_D | ST_C);           // low digit borrow
    send_op(MODE_SBC, 8'h00, 8'h01, ST_D | ST_C);           // negative difference
    send_op(MODE_SBC, 8'h00, 8'h00, ST_D);                  // borrow in from C clear
    send_op(MODE_CMP, 8'h10, 8'h10, 8'h00);
    send_op(MODE_CMP, 8'h00, 8'hFF, ST_V | ST_D);
    send_op(MODE_ASL, 8'h00, 8'h80, 8'h00);
    send_op(MODE_LSR, 8'h00, 8'h01, ST_N);
    send_op(MODE_ROL, 8'h00, 8'h80, ST_C);
    send_op(MODE_ROR, 8'h00, 8'h01, 8'h00);
    send_op(MODE_BIT, 8'h00, 8'hC0, 8'h00);
    send_op(MODE_SPARE, 8'hFF, 8'hFF, 8'hFF);
    send_op(MODE_SPARE + 4'd1, 8'h12, 8'h34, 8'h5A);
    send_op(MODE_SPARE + 4'd2, 8'hA5, 8'h5A, 8'h00);
  endtask

  task automatic test_random_traffic(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_random_op();
  endtask

  // Result side held off long enough for both registers to fill and in_tready to drop.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    stall_cycles_left = 300;
    repeat (40) send_random_op();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 20;
    recv_stall_pct = 40;
    repeat (10) send_random_op();
    drop_valid();
    wait (alu_results_due.size() == 0);
    repeat (10) send_random_op();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(320, 13, 85);
    test_random_traffic(320, 85, 13);
    test_random_traffic(320, 0, 0);
    test_output_hold();
    test_drain_pause();
    drop_valid();
    recv_stall_pct = 0;
    wait (alu_results_due.size() == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d operations and checked %0d results: every op code, binary and", ops_sent,
             results_seen);
    $display("decimal add/subtract, unused codes, input and output stalls, long output hold.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("Timed out with %0d results outstanding", alu_results_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
